FILE: rtl/clcd_pkg.sv
package clcd_pkg;

   localparam int WAIT_BITS = 18;
   localparam int CFG_W     = 18;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_CMD  = 2'd1,
      OP_CHAR = 2'd2,
      OP_INIT = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PULSE_TICKS = 3'd0,
      REG_POLL_LIMIT  = 3'd1,
      REG_POWER_UP    = 3'd2,
      REG_LONG_INIT   = 3'd3,
      REG_SHORT_INIT  = 3'd4,
      REG_CLEAR_WAIT  = 3'd5
   } csr_idx_type;

   typedef enum logic [4:0] {
      PH_IDLE     = 5'd0,
      PH_PU_WAIT  = 5'd1,
      PH_INI_SET  = 5'd2,
      PH_INI_HIGH = 5'd3,
      PH_INI_GAP  = 5'd4,
      PH_CLR_WAIT = 5'd5,
      PH_BR_SET   = 5'd6,
      PH_BR_HIGH  = 5'd7,
      PH_BR_LOW   = 5'd8,
      PH_BR_HIGH2 = 5'd9,
      PH_HI_SET   = 5'd10,
      PH_HI_HIGH  = 5'd11,
      PH_LO_SET   = 5'd12,
      PH_LO_HIGH  = 5'd13
   } phase_type;

   typedef struct packed {
      logic       drive;
      logic [3:0] nibble;
      logic       en;
      logic       rw;
      logic       rs;
   } pin_type;

   localparam pin_type PINS_DRIVEN = '{drive: 1'b1, nibble: 4'h0, en: 1'b0, rw: 1'b0,
                                       rs: 1'b0};
   localparam pin_type PINS_READ   = '{drive: 1'b0, nibble: 4'h0, en: 1'b0, rw: 1'b1,
                                       rs: 1'b0};

   localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
   localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
   localparam logic [7:0] CMD_CLEAR     = 8'h01;
   localparam logic [7:0] CMD_ENTRY     = 8'h06;
   localparam logic [3:0] NIB_WAKE      = 4'h3;
   localparam logic [3:0] NIB_FOUR_BIT  = 4'h2;

   localparam logic [2:0] STEP_FUNC_SET = 3'd4;
   localparam logic [2:0] STEP_DISP_ON  = 3'd5;
   localparam logic [2:0] STEP_CLEAR    = 3'd6;
   localparam logic [2:0] STEP_ENTRY    = 3'd7;
   localparam logic [2:0] STEP_LAST_NIB = 3'd3;

endpackage

FILE: rtl/char_lcd_4bit_interface.sv
// Character LCD sequencer, 4-bit bus.
// Each result is registered and offered in the cycle after its input transfer.
// Throughput: one item per cycle while results are taken; the sequencer state
// is updated as an item is taken; its pin levels land in the result register.
// Reset (synchronous, active high): idle, all pins low with the bus driven,
// configuration back to its defaults, result register empty.
module char_lcd_4bit_interface (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_op,
   input  logic [7:0]                      req_byte_value,
   input  logic                            req_busy_level,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_rs_level,
   output logic                            rsp_rw_level,
   output logic                            rsp_en_level,
   output logic [3:0]                      rsp_nibble_out,
   output logic                            rsp_drive_bus,
   output logic                            rsp_ready_res,
   output logic                            rsp_rejected,
   input  logic                            csr_we,
   input  logic [clcd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [clcd_pkg::CFG_W-1:0]      csr_wdata
);

   localparam int WB = clcd_pkg::WAIT_BITS;

   // configuration
   logic [7:0]                    pulse_ticks_ff;
   logic [7:0]                    poll_limit_ff;
   logic [clcd_pkg::CFG_W-1:0]    power_up_ff;
   logic [clcd_pkg::CFG_W-1:0]    long_init_ff;
   logic [clcd_pkg::CFG_W-1:0]    short_init_ff;
   logic [clcd_pkg::CFG_W-1:0]    clear_wait_ff;

   // sequencer state
   clcd_pkg::phase_type phase_ff, phase_in;
   logic [WB-1:0]       wait_ff, wait_in;
   logic [7:0]          poll_ff, poll_in;
   logic [7:0]          held_ff, held_in;
   logic [2:0]          step_ff, step_in;
   logic                sel_data_ff, sel_data_in;
   logic                busy_ff, busy_in;
   clcd_pkg::pin_type   pins_ff, pins_in;

   // result register
   logic                rsp_valid_ff;
   logic                rs_ff, rw_ff, en_ff, drive_ff, ready_ff, rej_ff;
   logic [3:0]          nib_ff;

   logic                accept;
   logic                rej_in;
   logic                start_byte;
   logic [7:0]          start_val;
   logic                start_rs;
   clcd_pkg::op_type    op;

   assign op        = clcd_pkg::op_type'(req_op);
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_ticks_ff <= 8'd1;
         poll_limit_ff  <= 8'd200;
         power_up_ff    <= clcd_pkg::CFG_W'(150000);
         long_init_ff   <= clcd_pkg::CFG_W'(5000);
         short_init_ff  <= clcd_pkg::CFG_W'(150);
         clear_wait_ff  <= clcd_pkg::CFG_W'(2000);
      end else if (csr_we) begin
         case (csr_index)
            clcd_pkg::REG_PULSE_TICKS: pulse_ticks_ff <= csr_wdata[7:0];
            clcd_pkg::REG_POLL_LIMIT:  poll_limit_ff  <= csr_wdata[7:0];
            clcd_pkg::REG_POWER_UP:    power_up_ff    <= csr_wdata;
            clcd_pkg::REG_LONG_INIT:   long_init_ff   <= csr_wdata;
            clcd_pkg::REG_SHORT_INIT:  short_init_ff  <= csr_wdata;
            clcd_pkg::REG_CLEAR_WAIT:  clear_wait_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      wait_in     = wait_ff;
      poll_in     = poll_ff;
      held_in     = held_ff;
      step_in     = step_ff;
      sel_data_in = sel_data_ff;
      busy_in     = busy_ff;
      pins_in     = pins_ff;
      rej_in      = 1'b0;
      start_byte  = 1'b0;
      start_val   = held_ff;
      start_rs    = 1'b0;

      if (op == clcd_pkg::OP_TICK) begin
         if (phase_ff != clcd_pkg::PH_IDLE) begin
            if (wait_ff > WB'(1)) begin
               wait_in = wait_ff - WB'(1);
            end else begin
               unique case (phase_ff)
                  clcd_pkg::PH_PU_WAIT: begin
                     pins_in.nibble = clcd_pkg::NIB_WAKE;
                     phase_in       = clcd_pkg::PH_INI_SET;
                     wait_in        = WB'(pulse_ticks_ff);
                  end
                  clcd_pkg::PH_INI_SET: begin
                     pins_in.en = 1'b1;
                     phase_in   = clcd_pkg::PH_INI_HIGH;
                     wait_in    = WB'(pulse_ticks_ff);
                  end
                  clcd_pkg::PH_INI_HIGH: begin
                     pins_in.en = 1'b0;
                     phase_in   = clcd_pkg::PH_INI_GAP;
                     wait_in    = (step_ff == 3'd0) ? WB'(long_init_ff) : WB'(short_init_ff);
                     step_in    = step_ff + 3'd1;
                  end
                  clcd_pkg::PH_INI_GAP: begin
                     if (step_ff < clcd_pkg::STEP_FUNC_SET) begin
                        pins_in.nibble = (step_ff == clcd_pkg::STEP_LAST_NIB) ?
                                         clcd_pkg::NIB_FOUR_BIT : clcd_pkg::NIB_WAKE;
                        phase_in       = clcd_pkg::PH_INI_SET;
                        wait_in        = WB'(pulse_ticks_ff);
                     end else begin
                        step_in    = clcd_pkg::STEP_FUNC_SET;
                        start_byte = 1'b1;
                        start_val  = clcd_pkg::CMD_FUNC_SET;
                     end
                  end
                  clcd_pkg::PH_CLR_WAIT: begin
                     step_in    = clcd_pkg::STEP_ENTRY;
                     start_byte = 1'b1;
                     start_val  = clcd_pkg::CMD_ENTRY;
                  end
                  clcd_pkg::PH_BR_SET: begin
                     pins_in.en = 1'b1;
                     phase_in   = clcd_pkg::PH_BR_HIGH;
                     wait_in    = WB'(pulse_ticks_ff);
                  end
                  clcd_pkg::PH_BR_HIGH: begin
                     busy_in    = req_busy_level;
                     pins_in.en = 1'b0;
                     phase_in   = clcd_pkg::PH_BR_LOW;
                     wait_in    = WB'(pulse_ticks_ff);
                  end
                  clcd_pkg::PH_BR_LOW: begin
                     pins_in.en = 1'b1;
                     phase_in   = clcd_pkg::PH_BR_HIGH2;
                     wait_in    = WB'(pulse_ticks_ff);
                  end
                  clcd_pkg::PH_BR_HIGH2: begin
                     // not busy, or poll budget spent: put out the high nibble
                     if (!busy_ff || poll_ff >= poll_limit_ff) begin
                        pins_in        = clcd_pkg::PINS_DRIVEN;
                        pins_in.rs     = sel_data_ff;
                        pins_in.nibble = held_ff[7:4];
                        phase_in       = clcd_pkg::PH_HI_SET;
                     end else begin
                        pins_in.en = 1'b0;
                        poll_in    = poll_ff + 8'd1;
                        phase_in   = clcd_pkg::PH_BR_SET;
                     end
                     wait_in = WB'(pulse_ticks_ff);
                  end
                  clcd_pkg::PH_HI_SET: begin
                     pins_in.en = 1'b1;
                     phase_in   = clcd_pkg::PH_HI_HIGH;
                     wait_in    = WB'(pulse_ticks_ff);
                  end
                  clcd_pkg::PH_HI_HIGH: begin
                     pins_in.en     = 1'b0;
                     pins_in.nibble = held_ff[3:0];
                     phase_in       = clcd_pkg::PH_LO_SET;
                     wait_in        = WB'(pulse_ticks_ff);
                  end
                  clcd_pkg::PH_LO_SET: begin
                     pins_in.en = 1'b1;
                     phase_in   = clcd_pkg::PH_LO_HIGH;
                     wait_in    = WB'(pulse_ticks_ff);
                  end
                  clcd_pkg::PH_LO_HIGH: begin
                     pins_in.en = 1'b0;
                     if (step_ff == clcd_pkg::STEP_FUNC_SET) begin
                        step_in    = clcd_pkg::STEP_DISP_ON;
                        start_byte = 1'b1;
                        start_val  = clcd_pkg::CMD_DISP_ON;
                     end else if (step_ff == clcd_pkg::STEP_DISP_ON) begin
                        step_in    = clcd_pkg::STEP_CLEAR;
                        start_byte = 1'b1;
                        start_val  = clcd_pkg::CMD_CLEAR;
                     end else if (step_ff == clcd_pkg::STEP_CLEAR) begin
                        phase_in = clcd_pkg::PH_CLR_WAIT;
                        wait_in  = WB'(clear_wait_ff);
                     end else begin
                        if (step_ff == clcd_pkg::STEP_ENTRY) begin
                           step_in = 3'd0;
                        end
                        phase_in = clcd_pkg::PH_IDLE;
                        wait_in  = '0;
                     end
                  end
                  default: begin
                     phase_in = clcd_pkg::PH_IDLE;
                     wait_in  = '0;
                  end
               endcase
            end
         end
      end else if (phase_ff != clcd_pkg::PH_IDLE) begin
         rej_in = 1'b1;
      end else if (op == clcd_pkg::OP_INIT) begin
         step_in  = 3'd0;
         pins_in  = clcd_pkg::PINS_DRIVEN;
         phase_in = clcd_pkg::PH_PU_WAIT;
         wait_in  = WB'(power_up_ff);
      end else begin
         start_byte = 1'b1;
         start_val  = req_byte_value;
         start_rs   = (op == clcd_pkg::OP_CHAR);
      end

      if (start_byte) begin
         held_in     = start_val;
         sel_data_in = start_rs;
         poll_in     = 8'd0;
         pins_in     = clcd_pkg::PINS_READ;
         phase_in    = clcd_pkg::PH_BR_SET;
         wait_in     = WB'(pulse_ticks_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= clcd_pkg::PH_IDLE;
         wait_ff     <= '0;
         poll_ff     <= 8'd0;
         held_ff     <= 8'd0;
         step_ff     <= 3'd0;
         sel_data_ff <= 1'b0;
         busy_ff     <= 1'b0;
         pins_ff     <= clcd_pkg::PINS_DRIVEN;
      end else if (accept) begin
         phase_ff    <= phase_in;
         wait_ff     <= wait_in;
         poll_ff     <= poll_in;
         held_ff     <= held_in;
         step_ff     <= step_in;
         sel_data_ff <= sel_data_in;
         busy_ff     <= busy_in;
         pins_ff     <= pins_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rs_ff    <= pins_in.rs;
         rw_ff    <= pins_in.rw;
         en_ff    <= pins_in.en;
         nib_ff   <= pins_in.drive ? pins_in.nibble : 4'h0;
         drive_ff <= pins_in.drive;
         ready_ff <= (phase_in == clcd_pkg::PH_IDLE);
         rej_ff   <= rej_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_rs_level   = rs_ff;
   assign rsp_rw_level   = rw_ff;
   assign rsp_en_level   = en_ff;
   assign rsp_nibble_out = nib_ff;
   assign rsp_drive_bus  = drive_ff;
   assign rsp_ready_res  = ready_ff;
   assign rsp_rejected   = rej_ff;

endmodule

FILE: rtl/clcd_checker.sv
module clcd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            rsp_rs_level,
   input logic                            rsp_rw_level,
   input logic                            rsp_en_level,
   input logic [3:0]                      rsp_nibble_out,
   input logic                            rsp_drive_bus,
   input logic                            rsp_ready_res,
   input logic                            rsp_rejected
);

   // every accepted item yields a result on the next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("no result after an input transfer");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_nibble_out)
                                 && $stable(rsp_ready_res) && $stable(rsp_rejected))
      else $error("stalled result changed");

   // bus released only for busy reads, with RW high
   a_rw_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_rw_level != rsp_drive_bus)
                    && (rsp_drive_bus || (rsp_nibble_out == 4'h0)))
      else $error("bus direction and RW disagree");

   a_rejected_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |-> !rsp_ready_res)
      else $error("rejection reported while idle");

   a_idle_pins: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready_res |-> !rsp_en_level && rsp_drive_bus)
      else $error("idle with EN high or bus released");

endmodule

bind char_lcd_4bit_interface clcd_checker u_clcd_checker (.*);

FILE: tb/tb_char_lcd_4bit_interface.sv
`timescale 1ns / 100ps

module tb_char_lcd_4bit_interface;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 4;
   localparam int MAX_REPORTS    = 40;

   // indexes past the register list; writes there must be ignored
   localparam logic [clcd_pkg::CSR_IDX_W-1:0] REG_SPARE_A = 3'd6;
   localparam logic [clcd_pkg::CSR_IDX_W-1:0] REG_SPARE_B = 3'd7;

   typedef struct {
      logic       rs;
      logic       rw;
      logic       en;
      logic [3:0] nibble;
      logic       drive;
      logic       ready;
      logic       rejected;
   } pin_result_type;

   class lcd_pin_scoreboard;
      logic [clcd_pkg::CFG_W-1:0]     pulse_len;
      logic [7:0]                     poll_limit;
      logic [clcd_pkg::CFG_W-1:0]     power_up_len, long_gap_len, short_gap_len, clear_len;
      clcd_pkg::phase_type            phase;
      logic [clcd_pkg::WAIT_BITS-1:0] ticks_left;
      logic [7:0]                     polls, held_byte;
      logic [2:0]                     init_step;
      logic                           data_sel, busy_seen;
      clcd_pkg::pin_type              pins;
      pin_result_type                 pins_due_q[$];
      int errors, items, results, turned_away, inits_done, polls_abandoned;

      function new();
         pulse_len     = 18'd1;
         poll_limit    = 8'd200;
         power_up_len  = 18'd150000;
         long_gap_len  = 18'd5000;
         short_gap_len = 18'd150;
         clear_len     = 18'd2000;
         phase         = clcd_pkg::PH_IDLE;
         ticks_left    = '0;
         polls         = '0;
         held_byte     = '0;
         init_step     = '0;
         data_sel      = 1'b0;
         busy_seen     = 1'b0;
         pins          = clcd_pkg::PINS_DRIVEN;
         errors = 0; items = 0; results = 0;
         turned_away = 0; inits_done = 0; polls_abandoned = 0;
      endfunction

      function void note_config(logic [clcd_pkg::CSR_IDX_W-1:0] idx,
                                logic [clcd_pkg::CFG_W-1:0] val);
         case (idx)
            clcd_pkg::REG_PULSE_TICKS: pulse_len     = clcd_pkg::CFG_W'(val[7:0]);
            clcd_pkg::REG_POLL_LIMIT:  poll_limit    = val[7:0];
            clcd_pkg::REG_POWER_UP:    power_up_len  = val;
            clcd_pkg::REG_LONG_INIT:   long_gap_len  = val;
            clcd_pkg::REG_SHORT_INIT:  short_gap_len = val;
            clcd_pkg::REG_CLEAR_WAIT:  clear_len     = val;
            default: ;
         endcase
      endfunction

      function void start_wait(clcd_pkg::phase_type p, logic [clcd_pkg::CFG_W-1:0] len);
         phase      = p;
         ticks_left = len[clcd_pkg::WAIT_BITS-1:0];
      endfunction

      function void start_byte(logic [7:0] b, logic sel);
         held_byte = b;
         data_sel  = sel;
         polls     = '0;
         pins      = clcd_pkg::PINS_READ;
         start_wait(clcd_pkg::PH_BR_SET, pulse_len);
      endfunction

      function void byte_sent();
         case (init_step)
            clcd_pkg::STEP_FUNC_SET: begin
               init_step = clcd_pkg::STEP_DISP_ON;
               start_byte(clcd_pkg::CMD_DISP_ON, 1'b0);
            end
            clcd_pkg::STEP_DISP_ON: begin
               init_step = clcd_pkg::STEP_CLEAR;
               start_byte(clcd_pkg::CMD_CLEAR, 1'b0);
            end
            clcd_pkg::STEP_CLEAR: start_wait(clcd_pkg::PH_CLR_WAIT, clear_len);
            clcd_pkg::STEP_ENTRY: begin
               init_step = '0;
               inits_done++;
               start_wait(clcd_pkg::PH_IDLE, '0);
            end
            default: start_wait(clcd_pkg::PH_IDLE, '0);
         endcase
      endfunction

      function void interval_done(logic busy);
         case (phase)
            clcd_pkg::PH_PU_WAIT: begin
               pins.nibble = clcd_pkg::NIB_WAKE;
               start_wait(clcd_pkg::PH_INI_SET, pulse_len);
            end
            clcd_pkg::PH_INI_SET: begin
               pins.en = 1'b1;
               start_wait(clcd_pkg::PH_INI_HIGH, pulse_len);
            end
            clcd_pkg::PH_INI_HIGH: begin
               pins.en = 1'b0;
               start_wait(clcd_pkg::PH_INI_GAP,
                          (init_step == '0) ? long_gap_len : short_gap_len);
               init_step = init_step + 3'd1;
            end
            clcd_pkg::PH_INI_GAP: begin
               if (init_step < clcd_pkg::STEP_FUNC_SET) begin
                  pins.nibble = (init_step == clcd_pkg::STEP_LAST_NIB) ?
                                clcd_pkg::NIB_FOUR_BIT : clcd_pkg::NIB_WAKE;
                  start_wait(clcd_pkg::PH_INI_SET, pulse_len);
               end else begin
                  init_step = clcd_pkg::STEP_FUNC_SET;
                  start_byte(clcd_pkg::CMD_FUNC_SET, 1'b0);
               end
            end
            clcd_pkg::PH_CLR_WAIT: begin
               init_step = clcd_pkg::STEP_ENTRY;
               start_byte(clcd_pkg::CMD_ENTRY, 1'b0);
            end
            clcd_pkg::PH_BR_SET: begin
               pins.en = 1'b1;
               start_wait(clcd_pkg::PH_BR_HIGH, pulse_len);
            end
            clcd_pkg::PH_BR_HIGH: begin
               // DB7 only counts at the end of the first EN-high of a read
               busy_seen = busy;
               pins.en   = 1'b0;
               start_wait(clcd_pkg::PH_BR_LOW, pulse_len);
            end
            clcd_pkg::PH_BR_LOW: begin
               pins.en = 1'b1;
               start_wait(clcd_pkg::PH_BR_HIGH2, pulse_len);
            end
            clcd_pkg::PH_BR_HIGH2: begin
               pins.en = 1'b0;
               if (!busy_seen || polls >= poll_limit) begin
                  if (busy_seen) polls_abandoned++;
                  pins        = clcd_pkg::PINS_DRIVEN;
                  pins.rs     = data_sel;
                  pins.nibble = held_byte[7:4];
                  start_wait(clcd_pkg::PH_HI_SET, pulse_len);
               end else begin
                  polls = polls + 8'd1;
                  start_wait(clcd_pkg::PH_BR_SET, pulse_len);
               end
            end
            clcd_pkg::PH_HI_SET: begin
               pins.en = 1'b1;
               start_wait(clcd_pkg::PH_HI_HIGH, pulse_len);
            end
            clcd_pkg::PH_HI_HIGH: begin
               pins.en     = 1'b0;
               pins.nibble = held_byte[3:0];
               start_wait(clcd_pkg::PH_LO_SET, pulse_len);
            end
            clcd_pkg::PH_LO_SET: begin
               pins.en = 1'b1;
               start_wait(clcd_pkg::PH_LO_HIGH, pulse_len);
            end
            clcd_pkg::PH_LO_HIGH: begin
               pins.en = 1'b0;
               byte_sent();
            end
            default: start_wait(clcd_pkg::PH_IDLE, '0);
         endcase
      endfunction

      function void note_input(clcd_pkg::op_type op, logic [7:0] b, logic busy);
         pin_result_type r;
         logic           turned;
         turned = 1'b0;
         items++;
         if (op == clcd_pkg::OP_TICK) begin
            if (phase != clcd_pkg::PH_IDLE) begin
               if (ticks_left > 1) ticks_left = ticks_left - 1'b1;
               else interval_done(busy);
            end
         end else if (phase != clcd_pkg::PH_IDLE) begin
            turned = 1'b1;
            turned_away++;
         end else if (op == clcd_pkg::OP_INIT) begin
            init_step = '0;
            pins      = clcd_pkg::PINS_DRIVEN;
            start_wait(clcd_pkg::PH_PU_WAIT, power_up_len);
         end else begin
            start_byte(b, op == clcd_pkg::OP_CHAR);
         end
         r.rs       = pins.rs;
         r.rw       = pins.rw;
         r.en       = pins.en;
         r.nibble   = pins.drive ? pins.nibble : 4'h0;
         r.drive    = pins.drive;
         r.ready    = (phase == clcd_pkg::PH_IDLE);
         r.rejected = turned;
         pins_due_q.push_back(r);
      endfunction

      task report_mismatch(string what);
         errors++;
         if (errors <= MAX_REPORTS) $display("mismatch: %s", what);
      endtask

      task check_result(pin_result_type got);
         pin_result_type want;
         results++;
         if (pins_due_q.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing outstanding", results));
            return;
         end
         want = pins_due_q.pop_front();
         if (got.rs !== want.rs)
            report_mismatch($sformatf("result %0d rs_level %b, want %b",
                                      results, got.rs, want.rs));
         if (got.rw !== want.rw)
            report_mismatch($sformatf("result %0d rw_level %b, want %b",
                                      results, got.rw, want.rw));
         if (got.en !== want.en)
            report_mismatch($sformatf("result %0d en_level %b, want %b",
                                      results, got.en, want.en));
         if (got.nibble !== want.nibble)
            report_mismatch($sformatf("result %0d nibble_out %h, want %h",
                                      results, got.nibble, want.nibble));
         if (got.drive !== want.drive)
            report_mismatch($sformatf("result %0d drive_bus %b, want %b",
                                      results, got.drive, want.drive));
         if (got.ready !== want.ready)
            report_mismatch($sformatf("result %0d ready_res %b, want %b",
                                      results, got.ready, want.ready));
         if (got.rejected !== want.rejected)
            report_mismatch($sformatf("result %0d rejected %b, want %b",
                                      results, got.rejected, want.rejected));
      endtask

      function int pending();
         return pins_due_q.size();
      endfunction

      function bit seq_idle();
         return phase == clcd_pkg::PH_IDLE;
      endfunction
   endclass

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   logic [1:0]                     req_op;
   logic [7:0]                     req_byte_value;
   logic                           req_busy_level;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic                           rsp_rs_level;
   logic                           rsp_rw_level;
   logic                           rsp_en_level;
   logic [3:0]                     rsp_nibble_out;
   logic                           rsp_drive_bus;
   logic                           rsp_ready_res;
   logic                           rsp_rejected;
   logic                           csr_we;
   logic [clcd_pkg::CSR_IDX_W-1:0] csr_index;
   logic [clcd_pkg::CFG_W-1:0]     csr_wdata;

   lcd_pin_scoreboard sb = new();

   int send_gap_pct = 0;
   int stall_pct    = 0;
   int hold_off     = 0;
   int busy_odds    = 0;
   int quiet_cycles;

   char_lcd_4bit_interface dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_byte_value (req_byte_value),
      .req_busy_level (req_busy_level),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_rs_level   (rsp_rs_level),
      .rsp_rw_level   (rsp_rw_level),
      .rsp_en_level   (rsp_en_level),
      .rsp_nibble_out (rsp_nibble_out),
      .rsp_drive_bus  (rsp_drive_bus),
      .rsp_ready_res  (rsp_ready_res),
      .rsp_rejected   (rsp_rejected),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // result side: own stall pattern, plus a long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off > 0) begin
            rsp_ready <= 1'b0;
            hold_off--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      pin_result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.rs       = rsp_rs_level;
         got.rw       = rsp_rw_level;
         got.en       = rsp_en_level;
         got.nibble   = rsp_nibble_out;
         got.drive    = rsp_drive_bus;
         got.ready    = rsp_ready_res;
         got.rejected = rsp_rejected;
         sb.check_result(got);
      end
   end

   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("tb_char_lcd_4bit_interface: FAIL");
      $finish;
   end

   task automatic send_item(input clcd_pkg::op_type op, input logic [7:0] value,
                            input logic busy);
      @(negedge clock);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_byte_value <= value;
      req_busy_level <= busy;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_input(op, value, busy);
   endtask

   task automatic write_reg(input logic [clcd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [clcd_pkg::CFG_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.note_config(idx, val);
   endtask

   task automatic program_regs(input logic [clcd_pkg::CFG_W-1:0] pulse,
                               input logic [clcd_pkg::CFG_W-1:0] poll,
                               input logic [clcd_pkg::CFG_W-1:0] pwr,
                               input logic [clcd_pkg::CFG_W-1:0] lng,
                               input logic [clcd_pkg::CFG_W-1:0] sht,
                               input logic [clcd_pkg::CFG_W-1:0] clr);
      write_reg(clcd_pkg::REG_PULSE_TICKS, pulse);
      write_reg(clcd_pkg::REG_POLL_LIMIT, poll);
      write_reg(clcd_pkg::REG_POWER_UP, pwr);
      write_reg(clcd_pkg::REG_LONG_INIT, lng);
      write_reg(clcd_pkg::REG_SHORT_INIT, sht);
      write_reg(clcd_pkg::REG_CLEAR_WAIT, clr);
      @(negedge clock) csr_we <= 1'b0;
   endtask

   // tick the sequencer back to idle, then let every result drain
   task automatic quiesce(input int odds);
      while (!sb.seq_idle())
         send_item(clcd_pkg::OP_TICK, 8'($urandom), $urandom_range(99) < odds);
      @(negedge clock) req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mostly ticks; requests when idle, the odd refused request while busy
   task automatic mixed_traffic(input int count, input bit with_init);
      int               pick;
      clcd_pkg::op_type op;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (sb.seq_idle()) begin
            if (pick < 10) op = clcd_pkg::OP_TICK;
            else if (pick < 50) op = clcd_pkg::OP_CMD;
            else if (pick < 85 || !with_init) op = clcd_pkg::OP_CHAR;
            else op = clcd_pkg::OP_INIT;
            if (op != clcd_pkg::OP_TICK) begin
               case ($urandom_range(3))
                  0: busy_odds = 0;
                  1: busy_odds = 35;
                  2: busy_odds = 75;
                  default: busy_odds = 100;
               endcase
            end
         end else if (pick < 5) begin
            op = clcd_pkg::op_type'(2'($urandom_range(3, 1)));
         end else begin
            op = clcd_pkg::OP_TICK;
         end
         send_item(op, 8'($urandom), $urandom_range(99) < busy_odds);
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_op         = clcd_pkg::OP_TICK;
      req_byte_value = '0;
      req_busy_level = 1'b0;
      csr_we         = 1'b0;
      csr_index      = clcd_pkg::REG_PULSE_TICKS;
      csr_wdata      = '0;
      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      @(posedge clock);

      // reset settings: idle tick, refused requests, one busy re-read
      send_item(clcd_pkg::OP_TICK, 8'hFF, 1'b1);
      send_item(clcd_pkg::OP_CMD, 8'hFF, 1'b0);
      send_item(clcd_pkg::OP_CMD, 8'h00, 1'b1);
      send_item(clcd_pkg::OP_CHAR, 8'hA5, 1'b0);
      send_item(clcd_pkg::OP_INIT, 8'h5A, 1'b1);
      for (int i = 0; i < 12; i++)
         send_item(clcd_pkg::OP_TICK, 8'(i * 21), i < 4);
      send_item(clcd_pkg::OP_CHAR, 8'h00, 1'b1);
      quiesce(0);

      // zero-length steps, no re-polling, pulse width masked down to zero
      write_reg(REG_SPARE_A, clcd_pkg::CFG_W'($urandom));
      write_reg(REG_SPARE_B, clcd_pkg::CFG_W'($urandom));
      program_regs(18'h3FF00, 18'd0, 18'd0, 18'd0, 18'd0, 18'd0);
      mixed_traffic(300, 1'b1);
      quiesce(50);

      send_gap_pct = 81;
      program_regs(18'd2, 18'd3, 18'd5, 18'd9, 18'd3, 18'd4);
      mixed_traffic(300, 1'b1);
      quiesce(50);

      send_gap_pct = 0;
      stall_pct    = 81;
      program_regs(18'd1, 18'd1, 18'd3, 18'd2, 18'd1, 18'd2);
      mixed_traffic(260, 1'b1);
      // result side holds off while requests keep coming, so the input backs up
      hold_off = 400;
      mixed_traffic(40, 1'b1);
      quiesce(50);

      send_gap_pct = 32;
      stall_pct    = 32;
      program_regs(18'd3, 18'd2, 18'd4, 18'd6, 18'd2, 18'd3);
      mixed_traffic(150, 1'b1);
      quiesce(50);
      mixed_traffic(150, 1'b1);
      quiesce(50);

      // wide pulses with the poll limit at its top value
      send_gap_pct = 0;
      stall_pct    = 0;
      program_regs(18'd40, 18'd255, 18'd0, 18'd0, 18'd0, 18'd0);
      send_item(clcd_pkg::OP_CMD, 8'h3C, 1'b0);
      quiesce(0);

      // full power-up, then a poll run to the limit
      program_regs(18'd1, 18'd20, 18'd30, 18'd3, 18'd2, 18'd1);
      send_item(clcd_pkg::OP_INIT, 8'($urandom), 1'b0);
      quiesce(0);
      send_item(clcd_pkg::OP_CHAR, 8'($urandom), 1'b1);
      quiesce(100);

      $display("covered %0d items, %0d results: %0d requests refused while busy, %0d power-ups",
               sb.items, sb.results, sb.turned_away, sb.inits_done);
      $display("busy polls abandoned at the limit: %0d; mismatches: %0d",
               sb.polls_abandoned, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb_char_lcd_4bit_interface: PASS");
      end else begin
         $display("tb_char_lcd_4bit_interface: FAIL");
      end
      $finish;
   end

endmodule
